FILE: src/adtk_pkg.sv
// shared types and constants for the streaming top-k threshold block
`default_nettype none

package adtk_pkg;

    localparam int VAL_W = 32;
    localparam int KC_W  = 9;

    localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};

    // what one cell hands to its right-hand neighbor
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    ge;
    } link_t;

endpackage

`default_nettype wire

FILE: src/abs_diff_top_k_threshold.sv
// top level: absolute difference, sorted insertion chain and threshold readout
// a result passes the difference register, the chain cells and the output register before it is offered
// throughput: one beat per cycle while out_ready stays high; every cell of
//   the insertion chain compares the new value in the same cycle
// reset: all cells hold the most negative value, item count zero, keep_count 1
`default_nettype none

module abs_diff_top_k_threshold
    import adtk_pkg::*;
#(
    parameter int MAX_KEEP = 256
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [KC_W-1:0]         cfg_wr_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [VAL_W-1:0] score_first,
    input  wire logic signed [VAL_W-1:0] score_second,
    input  wire logic                    start_of_set,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [VAL_W-1:0]      threshold,
    output logic                         filled
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = $clog2(MAX_KEEP);

    logic [KC_W-1:0]          keep_count_reg;
    logic                     s0_valid_reg;
    logic signed [VAL_W-1:0]  diff_reg;
    logic signed [VAL_W-1:0]  diff_next;
    logic                     clr_reg;
    logic                     s1_valid_reg;
    logic [CW-1:0]            items_seen_reg;
    logic [CW-1:0]            items_seen_next;
    logic [CW-1:0]            items_base;
    logic                     out_valid_reg;
    logic signed [VAL_W-1:0]  threshold_reg;
    logic                     filled_reg;

    logic signed [VAL_W:0]    d_ab;
    logic signed [VAL_W:0]    d_ba;
    logic signed [VAL_W:0]    d_pos;
    logic [31:0]              k_eff;
    logic [IW-1:0]            sel_idx;
    logic                     out_load;
    logic                     chain_en;
    logic                     in_beat;

    logic [MAX_KEEP-1:0][VAL_W-1:0] held;

    // handshake between stages
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign chain_en = s0_valid_reg && (!s1_valid_reg || out_load);
    assign in_ready = !s0_valid_reg || chain_en;
    assign in_beat  = in_valid && in_ready;

    // saturating absolute difference
    always_comb
    begin
        d_ab  = {score_first[VAL_W-1], score_first} - {score_second[VAL_W-1], score_second};
        d_ba  = {score_second[VAL_W-1], score_second} - {score_first[VAL_W-1], score_first};
        d_pos = d_ab[VAL_W] ? d_ba : d_ab;
        if (d_pos[VAL_W:VAL_W-1] != 2'b00)
        begin
            diff_next = MOST_POS;
        end
        else
        begin
            diff_next = d_pos[VAL_W-1:0];
        end
    end

    always_comb
    begin
        items_base = clr_reg ? '0 : items_seen_reg;
        if (items_base < CW'(MAX_KEEP))
        begin
            items_seen_next = items_base + CW'(1);
        end
        else
        begin
            items_seen_next = items_base;
        end
    end

    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            k_eff = 32'd1;
        end
        else if (32'(keep_count_reg) > 32'(MAX_KEEP))
        begin
            k_eff = 32'(MAX_KEEP);
        end
        else
        begin
            k_eff = 32'(keep_count_reg);
        end
        sel_idx = IW'(k_eff - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KC_W'(1);
        end
        else if (cfg_wr_en)
        begin
            keep_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            items_seen_reg <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (chain_en)
            begin
                s0_valid_reg <= 1'b0;
            end

            if (chain_en)
            begin
                s1_valid_reg   <= 1'b1;
                items_seen_reg <= items_seen_next;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            diff_reg <= diff_next;
            clr_reg  <= start_of_set;
        end
        if (out_load)
        begin
            threshold_reg <= held[sel_idx];
            filled_reg    <= (32'(items_seen_reg) >= k_eff);
        end
    end

    adtk_chain #(
        .MAX_KEEP (MAX_KEEP)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (chain_en),
        .clr   (clr_reg),
        .din   (diff_reg),
        .held  (held)
    );

    assign out_valid = out_valid_reg;
    assign threshold = threshold_reg;
    assign filled    = filled_reg;

    a_filled_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && filled |-> !threshold[VAL_W-1])
        else $error("filled result with negative threshold");

    a_unfilled_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !filled |-> threshold == MOST_NEG)
        else $error("unfilled result without most negative threshold");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        $signed(held[0]) >= $signed(held[1]))
        else $error("chain head out of order");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        items_seen_reg <= CW'(MAX_KEEP))
        else $error("item count beyond chain length");

endmodule

`default_nettype wire

FILE: src/adtk_cell.sv
// one slot of the sorted insertion chain
`default_nettype none

module adtk_cell
    import adtk_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    clr,
    input  wire logic signed [VAL_W-1:0] din,
    input  wire link_t                   left,
    output link_t                        right,
    output logic signed [VAL_W-1:0]      held
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic signed [VAL_W-1:0] cur;

    always_comb
    begin
        cur         = clr ? MOST_NEG : value_reg;
        right.value = cur;
        right.ge    = (cur >= din);
        if (right.ge)
        begin
            value_next = cur;
        end
        else if (left.ge)
        begin
            value_next = din;
        end
        else
        begin
            value_next = left.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= MOST_NEG;
        end
        else if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign held = value_reg;

endmodule

`default_nettype wire

FILE: src/adtk_chain.sv
// row of cells kept sorted in descending order
`default_nettype none

module adtk_chain
    import adtk_pkg::*;
#(
    parameter int MAX_KEEP = 256
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             clr,
    input  wire logic signed [VAL_W-1:0]          din,
    output logic        [MAX_KEEP-1:0][VAL_W-1:0] held
);

    link_t links [0:MAX_KEEP];

    assign links[0].value = MOST_NEG;
    assign links[0].ge    = 1'b1;

    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_cell
        adtk_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .clr   (clr),
            .din   (din),
            .left  (links[i]),
            .right (links[i+1]),
            .held  (held[i])
        );
    end

endmodule

`default_nettype wire

FILE: test/abs_diff_top_k_threshold_tb.sv
// testbench for abs_diff_top_k_threshold: directed table then random score pairs, checked beat by beat
`default_nettype none

module abs_diff_top_k_threshold_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import adtk_pkg::*;

    localparam int DEPTH      = 256;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_SHOWN  = 10;
    localparam int NPLAN      = 29;
    localparam int NPHASE     = 11;

    typedef enum bit {ROW_BEAT, ROW_SETUP} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [KC_W-1:0]         keep;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic                    sos;
        logic                    typed;
        logic signed [VAL_W-1:0] thr;
        logic                    full;
    } plan_row_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] thr;
        logic                    full;
    } reading_t;

    localparam logic signed [VAL_W-1:0] ONE = 32'sd1;
    localparam logic signed [VAL_W-1:0] ALL_ONES = -32'sd1;

    localparam plan_row_t PLAN [NPLAN] = '{
        '{ROW_BEAT,  9'd0,   32'sd0,   32'sd0,   1'b1, 1'b1, 32'sd0,   1'b1},
        '{ROW_BEAT,  9'd0,   MOST_POS, MOST_NEG, 1'b0, 1'b1, MOST_POS, 1'b1},
        '{ROW_BEAT,  9'd0,   MOST_NEG, MOST_POS, 1'b1, 1'b1, MOST_POS, 1'b1},
        '{ROW_BEAT,  9'd0,   MOST_NEG, MOST_NEG, 1'b1, 1'b1, 32'sd0,   1'b1},
        '{ROW_BEAT,  9'd0,   MOST_POS, 32'sd0,   1'b1, 1'b1, MOST_POS, 1'b1},
        '{ROW_BEAT,  9'd0,   ALL_ONES, MOST_POS, 1'b1, 1'b1, MOST_POS, 1'b1},
        '{ROW_BEAT,  9'd0,   32'sd0,   MOST_NEG, 1'b1, 1'b1, MOST_POS, 1'b1},
        '{ROW_BEAT,  9'd0,   ONE,      ALL_ONES, 1'b1, 1'b1, 32'sd2,   1'b1},
        '{ROW_SETUP, 9'd0,   32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   32'sh10000, 32'sh30000, 1'b1, 1'b1, 32'sh20000, 1'b1},
        '{ROW_SETUP, 9'd3,   32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   32'sd5,   32'sd2,   1'b1, 1'b1, MOST_NEG, 1'b0},
        '{ROW_BEAT,  9'd0,   32'sd2,   32'sd9,   1'b0, 1'b1, MOST_NEG, 1'b0},
        '{ROW_BEAT,  9'd0,   32'sd4,   32'sd1,   1'b0, 1'b1, 32'sd3,   1'b1},
        '{ROW_BEAT,  9'd0,   32'sd100, 32'sd0,   1'b0, 1'b1, 32'sd3,   1'b1},
        '{ROW_SETUP, 9'd1,   32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   32'sd0,   32'sd0,   1'b0, 1'b1, 32'sd100, 1'b1},
        '{ROW_SETUP, 9'd2,   32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   -32'sd8,  -32'sd8,  1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_SETUP, 9'd511, 32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   32'sd1,   32'sd2,   1'b1, 1'b1, MOST_NEG, 1'b0},
        '{ROW_BEAT,  9'd0,   MOST_POS, MOST_POS, 1'b0, 1'b1, MOST_NEG, 1'b0},
        '{ROW_SETUP, 9'd256, 32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   32'sd3,   32'sd3,   1'b0, 1'b1, MOST_NEG, 1'b0},
        '{ROW_SETUP, 9'd2,   32'sd0,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   -32'sd5,  32'sd5,   1'b0, 1'b0, 32'sd0,   1'b0},
        '{ROW_BEAT,  9'd0,   32'shAAAAAAAA, 32'sh55555555, 1'b0, 1'b0, 32'sd0, 1'b0},
        '{ROW_BEAT,  9'd0,   32'sh55555555, 32'shAAAAAAAA, 1'b0, 1'b0, 32'sd0, 1'b0},
        '{ROW_BEAT,  9'd0,   32'sh0000FFFF, 32'shFFFF0000, 1'b1, 1'b0, 32'sd0, 1'b0}
    };

    localparam logic signed [VAL_W-1:0] EDGE_VALUES [5] = '{MOST_NEG, MOST_POS, 32'sd0, ALL_ONES, ONE};

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [KC_W-1:0]         cfg_wr_data  = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic signed [VAL_W-1:0] score_first  = '0;
    logic signed [VAL_W-1:0] score_second = '0;
    logic                    start_of_set = 1'b0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic signed [VAL_W-1:0] threshold;
    logic                    filled;

    logic signed [VAL_W-1:0] ranked [DEPTH];
    int                      seen_count;
    logic [KC_W-1:0]         keep_reg = 9'd1;
    reading_t                thr_due [$];

    int mismatches = 0;
    int quiet      = 0;
    int stall_left = 0;
    int stall_odds = 0;
    int gap_odds   = 0;

    abs_diff_top_k_threshold #(.MAX_KEEP(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .score_first  (score_first),
        .score_second (score_second),
        .start_of_set (start_of_set),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .threshold    (threshold),
        .filled       (filled)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_keep(logic [KC_W-1:0] k);
        if (k == 0)
            return 1;
        if (k > DEPTH)
            return DEPTH;
        return int'(k);
    endfunction

    function automatic void clear_ranks();
        for (int i = 0; i < DEPTH; i++)
            ranked[i] = MOST_NEG;
        seen_count = 0;
    endfunction

    task automatic rank_diff(input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b,
                             input logic sos, output reading_t r);
        logic signed [VAL_W:0]   gap;
        logic signed [VAL_W-1:0] v;
        int                      slot;
        int                      k;
        if (sos)
            clear_ranks();
        gap = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (gap < 0)
            gap = -gap;
        v = gap[VAL_W-1] ? MOST_POS : gap[VAL_W-1:0];
        slot = 0;
        while (slot < DEPTH && ranked[slot] >= v)
            slot++;
        if (slot < DEPTH)
        begin
            for (int i = DEPTH - 1; i > slot; i--)
                ranked[i] = ranked[i-1];
            ranked[slot] = v;
        end
        if (seen_count < DEPTH)
            seen_count++;
        k = clamp_keep(keep_reg);
        r.thr  = ranked[k-1];
        r.full = (seen_count >= k);
    endtask

    task automatic send_beat(input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b,
                             input logic sos, input logic typed,
                             input logic signed [VAL_W-1:0] thr, input logic full);
        reading_t due;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        score_first  <= a;
        score_second <= b;
        start_of_set <= sos;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        rank_diff(a, b, sos, due);
        if (typed)
        begin
            due.thr  = thr;
            due.full = full;
        end
        thr_due.push_back(due);
    endtask

    task automatic set_keep(input logic [KC_W-1:0] v);
        in_valid <= 1'b0;
        while (thr_due.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        keep_reg = v;
    endtask

    task automatic pick_scores(output logic signed [VAL_W-1:0] a,
                               output logic signed [VAL_W-1:0] b);
        int r;
        r = $urandom_range(0, 9);
        if (r <= 3)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (r <= 6)
        begin
            a = $urandom_range(0, 32) - 16;
            b = $urandom_range(0, 32) - 16;
        end
        else if (r == 7)
        begin
            a = EDGE_VALUES[$urandom_range(0, 4)];
            b = EDGE_VALUES[$urandom_range(0, 4)];
        end
        else
        begin
            a = $urandom;
            b = a + $urandom_range(0, 64) - 32;
        end
    endtask

    always @(posedge clk)
    begin
        reading_t due;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (thr_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat: threshold %h filled %b", threshold, filled);
            end
            else
            begin
                due = thr_due.pop_front();
                if (threshold !== due.thr || filled !== due.full)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result mismatch: threshold exp %h got %h, filled exp %b got %b",
                                 due.thr, threshold, due.full, filled);
                end
            end
        end
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
                stall_left = $urandom_range(1, 8);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == IDLE_LIMIT)
        begin
            $display("abs_diff_top_k_threshold_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic                    sos;
        logic [KC_W-1:0]         kc;
        int                      eff;
        int                      span;
        int                      left;
        clear_ranks();
        left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds   = 4;
        stall_odds = 4;
        for (int i = 0; i < NPLAN; i++)
        begin
            if (PLAN[i].kind == ROW_SETUP)
                set_keep(PLAN[i].keep);
            else
                send_beat(PLAN[i].a, PLAN[i].b, PLAN[i].sos, PLAN[i].typed,
                          PLAN[i].thr, PLAN[i].full);
        end

        for (int p = 0; p < NPHASE; p++)
        begin
            case (p)
                0:       kc = 9'd1;
                1:       kc = 9'd0;
                2:       kc = 9'd5;
                3:       kc = 9'd256;
                4:       kc = 9'd3;
                5:       kc = 9'd17;
                6:       kc = 9'd511;
                7:       kc = 9'd2;
                8:       kc = 9'd100;
                9:       kc = KC_W'($urandom_range(1, 300));
                default: kc = 9'd8;
            endcase
            if (p == NPHASE - 1)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = $urandom_range(0, 2) * 4;
                stall_odds = $urandom_range(0, 2) * 4;
            end
            set_keep(kc);
            eff  = clamp_keep(kc);
            span = (eff >= 64) ? 260 : 70;
            // small settings sometimes carry the old set over
            if (eff >= 64 || $urandom_range(0, 1) == 1)
                left = 0;
            for (int n = 0; n < span; n++)
            begin
                sos = (left <= 0) || ($urandom_range(0, 49) == 0);
                if (sos)
                    left = ($urandom_range(0, 3) != 0) ? $urandom_range(eff, 2 * eff + 8)
                                                       : $urandom_range(1, eff);
                left--;
                pick_scores(a, b);
                send_beat(a, b, sos, 1'b0, '0, 1'b0);
            end
        end

        in_valid <= 1'b0;
        while (thr_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && thr_due.size() == 0)
            $display("abs_diff_top_k_threshold_tb OK");
        else
            $display("abs_diff_top_k_threshold_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
